>>> rtl/core/indexed_array_list_assert.svh
// assertion macros shared by the list core
`ifndef INDEXED_ARRAY_LIST_ASSERT_SVH
`define INDEXED_ARRAY_LIST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IAL_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IAL_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/core/ial_pkg.sv
package ial_pkg;

    localparam int CAPACITY  = 8;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 4;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 4;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic {
        ST_EMPTY,
        ST_LOADED
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

>>> rtl/core/ial_if.sv
interface ial_req_if
    import ial_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ial_rsp_if
    import ial_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]    count;
    logic                    is_empty;
    logic                    is_full;

    modport source (output valid, ok, read_value, count, is_empty, is_full, input ready);
    modport sink   (input valid, ok, read_value, count, is_empty, is_full, output ready);
endinterface

>>> rtl/core/indexed_array_list.sv
// channel | dir | payload                                    | transfer
// req     | in  | kind, position, value                      | valid && ready
// rsp     | out | ok, read_value, count, is_empty, is_full   | valid && ready
//
// an item is captured, then executed once the result register is free; capture
// of the following item overlaps execution: one item per cycle unless stalled
// the list is CAPACITY cells; those from an insert or delete position up shift
// the result sits in an output register until its transfer completes
// a stalled result holds the executing item back; one more item can wait captured
// rst_n clears the count and control state; list cells are not reset
module indexed_array_list
    import ial_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ial_req_if.sink   req,
    ial_rsp_if.source rsp
);

    ctrl_cmd_t cmd;

    ial_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    ial_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (req.kind),
        .position   (req.position),
        .value      (req.value),
        .ok         (rsp.ok),
        .read_value (rsp.read_value),
        .count      (rsp.count),
        .is_empty   (rsp.is_empty),
        .is_full    (rsp.is_full)
    );

endmodule

>>> rtl/core/ial_ctrl.sv
`include "indexed_array_list_assert.svh"

module ial_ctrl
    import ial_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        exec;
    logic        accept;

    // a captured item runs once the result register is free or being drained
    assign exec   = (state_reg == ST_LOADED) && (!out_valid_reg || rsp_ready);
    assign accept = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = ST_LOADED;
                end
            end
            ST_LOADED:
            begin
                if (exec && !accept)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_EMPTY:
            begin
                req_ready = 1'b1;
            end
            ST_LOADED:
            begin
                req_ready = exec;
                cmd.exec  = exec;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        cmd.load = accept;
    end

    always_comb
    begin
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    `IAL_ASSERT_IMPL(a_no_overwrite, out_valid_reg && !rsp_ready, !cmd.exec, "result overwritten while stalled")
    `IAL_ASSERT_IMPL(a_accept_loaded, accept && state_reg == ST_LOADED, cmd.exec, "item taken over a pending one")
    `IAL_ASSERT_NEXT(a_exec_shows, cmd.exec, out_valid_reg, "executed item not presented")

endmodule

>>> rtl/core/ial_datapath.sv
`include "indexed_array_list_assert.svh"

module ial_datapath
    import ial_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    input  logic [KIND_W-1:0]       kind,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    ok,
    output logic signed [VAL_W-1:0] read_value,
    output logic [CNT_OUT_W-1:0]    count,
    output logic                    is_empty,
    output logic                    is_full
);

    kind_t                kind_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [VAL_W-1:0]     value_reg;
    logic [VAL_W-1:0]     entries_reg [CAPACITY];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 rsp_ok_reg;
    logic [VAL_W-1:0]     rsp_read_reg;
    logic [CNT_OUT_W-1:0] rsp_count_reg;
    logic                 rsp_empty_reg;
    logic                 rsp_full_reg;

    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic [IDX_W-1:0]     idx;
    logic                 full;
    logic                 ins_ok;
    logic                 at_ok;
    logic                 ok_now;
    logic                 do_insert;
    logic                 do_delete;
    logic [VAL_W-1:0]     rd_now;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_t'(kind);
            pos_reg   <= position;
            value_reg <= value;
        end
    end

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx     = pos_ext[IDX_W-1:0];
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign ins_ok  = !full && (pos_ext <= cnt_ext);
    assign at_ok   = pos_ext < cnt_ext;

    always_comb
    begin
        ok_now     = 1'b0;
        count_next = count_reg;
        rd_now     = '0;
        case (kind_reg)
            KIND_INSERT:
            begin
                ok_now = ins_ok;
                if (ins_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_DELETE:
            begin
                ok_now = at_ok;
                if (at_ok)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_READ:
            begin
                ok_now = at_ok;
                if (at_ok)
                begin
                    rd_now = entries_reg[idx];
                end
            end
            default:
            begin
                ok_now     = 1'b1;
                count_next = '0;
            end
        endcase
    end

    assign do_insert = cmd.exec && (kind_reg == KIND_INSERT) && ins_ok;
    assign do_delete = cmd.exec && (kind_reg == KIND_DELETE) && at_ok;

    // cells above an insert position take their lower neighbor, cells from a delete position up the upper one
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VAL_W-1:0] up_src;
        logic [VAL_W-1:0] down_src;

        if (g == 0)
        begin : g_first
            assign up_src = value_reg;
        end
        else
        begin : g_rest
            assign up_src = entries_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign down_src = entries_reg[g];
        end
        else
        begin : g_inner
            assign down_src = entries_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (do_insert && (IDX_W'(g) == idx))
            begin
                entries_reg[g] <= value_reg;
            end
            else if (do_insert && (IDX_W'(g) > idx))
            begin
                entries_reg[g] <= up_src;
            end
            else if (do_delete && (IDX_W'(g) >= idx))
            begin
                entries_reg[g] <= down_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_ok_reg    <= ok_now;
            rsp_read_reg  <= rd_now;
            rsp_count_reg <= CNT_OUT_W'(count_next);
            rsp_empty_reg <= (count_next == '0);
            rsp_full_reg  <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign ok         = rsp_ok_reg;
    assign read_value = rsp_read_reg;
    assign count      = rsp_count_reg;
    assign is_empty   = rsp_empty_reg;
    assign is_full    = rsp_full_reg;

    `IAL_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `IAL_ASSERT_NEXT(a_insert_count, do_insert, count_reg == CNT_W'($past(count_reg) + 1'b1), "insert did not grow list")
    `IAL_ASSERT_NEXT(a_flags, cmd.exec, (rsp_empty_reg == (count_reg == '0)) && (rsp_full_reg == (count_reg == CNT_W'(CAPACITY))), "flags disagree with count")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ial_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 107;

    typedef struct {
        kind_t                   kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } list_op_t;

    typedef struct {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]    count;
        logic                    is_empty;
        logic                    is_full;
    } list_status_t;

    class list_scoreboard;
        logic signed [VAL_W-1:0] cells [CAPACITY];
        int unsigned             used;
        list_status_t            pending_status [$];
        int                      errors;
        int                      checked;
        int                      kind_seen [4];
        int                      refused;
        int                      full_hits;

        function int outstanding();
            return pending_status.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // apply one accepted operation to the shadow list
        function void note_op(kind_t kind, logic [POS_W-1:0] position,
                              logic signed [VAL_W-1:0] value);
            list_status_t st;
            int unsigned  pos;
            pos = position;
            st.ok = 1'b0;
            st.read_value = '0;
            kind_seen[kind]++;
            case (kind)
                KIND_INSERT:
                begin
                    if (used < CAPACITY && pos <= used)
                    begin
                        for (int k = used; k > pos; k--)
                            cells[k] = cells[k-1];
                        cells[pos] = value;
                        used++;
                        st.ok = 1'b1;
                    end
                end
                KIND_DELETE:
                begin
                    if (pos < used)
                    begin
                        for (int k = pos; k + 1 < used; k++)
                            cells[k] = cells[k+1];
                        used--;
                        st.ok = 1'b1;
                    end
                end
                KIND_READ:
                begin
                    if (pos < used)
                    begin
                        st.read_value = cells[pos];
                        st.ok = 1'b1;
                    end
                end
                default:
                begin
                    used = 0;
                    st.ok = 1'b1;
                end
            endcase
            if (!st.ok)
                refused++;
            if (used == CAPACITY)
                full_hits++;
            st.count    = CNT_OUT_W'(used);
            st.is_empty = (used == 0);
            st.is_full  = (used == CAPACITY);
            pending_status.push_back(st);
        endfunction

        task check_status(list_status_t got);
            list_status_t want;
            if (pending_status.size() == 0)
            begin
                report("result transfer with nothing outstanding");
                return;
            end
            want = pending_status.pop_front();
            checked++;
            if (got.ok !== want.ok)
                report($sformatf("ok %b, expected %b", got.ok, want.ok));
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %h, expected %h",
                                 got.read_value, want.read_value));
            if (got.count !== want.count)
                report($sformatf("count %0d, expected %0d", got.count, want.count));
            if (got.is_empty !== want.is_empty)
                report($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
            if (got.is_full !== want.is_full)
                report($sformatf("is_full %b, expected %b", got.is_full, want.is_full));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   cycles;

    list_scoreboard list_sb;

    ial_req_if req_ch ();
    ial_rsp_if rsp_ch ();

    indexed_array_list u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        list_sb = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cycles             = 0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = '0;
        req_ch.position    = '0;
        req_ch.value       = '0;
        rsp_ch.ready       = 1'b0;
    end

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("[indexed_array_list] ERROR");
            $finish;
        end
    end

    // accepted requests feed the shadow list
    always @(posedge clk)
        if (rst_n && req_ch.valid && req_ch.ready)
            list_sb.note_op(kind_t'(req_ch.kind), req_ch.position, req_ch.value);

    always @(posedge clk)
    begin
        list_status_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.ok         = rsp_ch.ok;
            got.read_value = rsp_ch.read_value;
            got.count      = rsp_ch.count;
            got.is_empty   = rsp_ch.is_empty;
            got.is_full    = rsp_ch.is_full;
            list_sb.check_status(got);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_op(list_op_t op);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= op.kind;
        req_ch.position <= op.position;
        req_ch.value    <= op.value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    function automatic list_op_t pick_op();
        list_op_t    op;
        int          r;
        int unsigned fill;
        fill = list_sb.used;
        r = $urandom_range(0, 99);
        if (fill < 3)
            op.kind = (r < 55) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
                      (r < 96) ? KIND_READ : KIND_CLEAR;
        else
            op.kind = (r < 38) ? KIND_INSERT : (r < 68) ? KIND_DELETE :
                      (r < 97) ? KIND_READ : KIND_CLEAR;
        // mostly in-range positions, some anywhere in the field
        if ($urandom_range(0, 99) < 85)
            op.position = POS_W'($urandom_range(0, fill));
        else
            op.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        op.value = $urandom;
        return op;
    endfunction

    function automatic list_op_t mk(kind_t kind, int position, logic [VAL_W-1:0] value);
        list_op_t op;
        op.kind     = kind;
        op.position = POS_W'(position);
        op.value    = value;
        return op;
    endfunction

    initial
    begin
        list_op_t directed [$];

        directed = '{
            mk(KIND_READ,   0,  32'h0),          // read on empty list
            mk(KIND_DELETE, 0,  32'h0),          // delete on empty list
            mk(KIND_CLEAR,  0,  32'h0),          // clear an empty list
            mk(KIND_INSERT, 1,  32'h1234_5678),  // position past count
            mk(KIND_INSERT, 0,  32'h7FFF_FFFF),
            mk(KIND_INSERT, 0,  32'h8000_0000),
            mk(KIND_INSERT, 2,  32'hFFFF_FFFF),  // append at the tail
            mk(KIND_INSERT, 1,  32'h0000_0000),
            mk(KIND_INSERT, 4,  32'h5555_5555),
            mk(KIND_INSERT, 0,  32'hAAAA_AAAA),
            mk(KIND_INSERT, 3,  32'h0000_0001),
            mk(KIND_INSERT, 7,  32'hC3A5_5A3C),  // list now full
            mk(KIND_INSERT, 0,  32'hDEAD_BEEF),  // insert into full list
            mk(KIND_READ,   7,  32'h0),
            mk(KIND_READ,   8,  32'h0),
            mk(KIND_READ,   15, 32'hFFFF_FFFF),
            mk(KIND_DELETE, 15, 32'h0),
            mk(KIND_DELETE, 7,  32'h0),          // drop the tail
            mk(KIND_DELETE, 0,  32'h0),          // drop the head
            mk(KIND_INSERT, 7,  32'h0F0F_0F0F),  // past count by one
            mk(KIND_READ,   0,  32'h0),
            mk(KIND_CLEAR,  5,  32'hFFFF_FFFF),
            mk(KIND_INSERT, 15, 32'h0000_0002),
            mk(KIND_READ,   0,  32'h0)
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_op(directed[i]);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_op(pick_op());
        end
        req_ch.valid <= 1'b0;

        while (list_sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d inserts, %0d deletes, %0d reads, %0d clears; %0d results checked",
                 list_sb.kind_seen[KIND_INSERT], list_sb.kind_seen[KIND_DELETE],
                 list_sb.kind_seen[KIND_READ], list_sb.kind_seen[KIND_CLEAR],
                 list_sb.checked);
        $display("%0d operations refused, list full after %0d operations, %0d mismatches",
                 list_sb.refused, list_sb.full_hits, list_sb.errors);
        if (list_sb.errors == 0 && list_sb.outstanding() == 0)
            $display("[indexed_array_list] OK");
        else
            $display("[indexed_array_list] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ial_pkg.sv
rtl/core/ial_if.sv
rtl/core/ial_ctrl.sv
rtl/core/ial_datapath.sv
rtl/core/indexed_array_list.sv
sim/tb_top.sv
